// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/trd_pkg.sv =====
// Types, constants and helper functions of the tracker reply deframer.
package trd_pkg;

    // Packet headers and address bytes
    localparam logic [7:0] HdrTrack  = 8'hBB;
    localparam logic [7:0] AddrTrack = 8'h01;
    localparam logic [7:0] HdrZoom   = 8'h90;
    localparam logic [7:0] AddrZoom  = 8'h50;

    // Byte position of the last byte in each packet kind
    localparam logic [2:0] LastTrack = 3'd7;
    localparam logic [2:0] LastZoom  = 3'd6;

    // Bit of the status byte that marks a held target
    localparam int HeldBit = 1;

    // Register reset values
    localparam logic [7:0] LostLimitRst      = 8'd90;
    localparam logic [7:0] NotifyIntervalRst = 8'd11;

    // Zoom position table
    localparam int ZoomSteps = 41;
    localparam int ZoomMax   = 29;

    typedef logic [15:0] t_zoom_rom [ZoomSteps];

    localparam t_zoom_rom ZoomRom = '{
        16'h0000, 16'h16A1, 16'h2063, 16'h2628, 16'h2A1D, 16'h2D13, 16'h2F6D, 16'h3161,
        16'h330D, 16'h3486, 16'h35D7, 16'h3709, 16'h3820, 16'h3920, 16'h3A0A, 16'h3ADD,
        16'h3B9C, 16'h3C46, 16'h3CDC, 16'h3D60, 16'h3DD4, 16'h3E39, 16'h3E90, 16'h3EDC,
        16'h3F1E, 16'h3F57, 16'h3F8A, 16'h3FB6, 16'h3FDC, 16'h4000, 16'h6000, 16'h6A80,
        16'h7000, 16'h7300, 16'h7540, 16'h76C0, 16'h7800, 16'h78C0, 16'h7980, 16'h7A00,
        16'h7AC0
    };

    // Twice the midpoint between a table step and the one below it
    function automatic logic [16:0] zoom_mid(input int idx);
        return {1'b0, ZoomRom[idx - 1]} + {1'b0, ZoomRom[idx]};
    endfunction

    // Configuration register indexes
    typedef enum logic {
        REG_LOST_LIMIT      = 1'b0,
        REG_NOTIFY_INTERVAL = 1'b1
    } t_reg_idx;

    // Result kinds
    typedef enum logic [1:0] {
        EV_TRACKED = 2'd0,
        EV_LOST    = 2'd1,
        EV_ZOOM    = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic [7:0] lost_limit;
        logic [7:0] notify_interval;
    } t_cfg;

    // View of the packet that the current byte completes
    typedef struct packed {
        logic               done;
        logic               is_zoom;
        logic [7:0]         addr;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               held;
        logic [15:0]        zpos;
    } t_frame;

    typedef struct packed {
        logic               valid;
        t_event_kind        event_kind;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic               notify_gimbal;
        logic               send_stop;
        logic [4:0]         zoom_index;
    } t_result;

endpackage

// ===== rtl/trd_in_if.sv =====
// Input channel: one received byte per transaction.
interface trd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       tracker_in_charge;

    modport source (output valid, rx_byte, tracker_in_charge, input ready);
    modport sink (input valid, rx_byte, tracker_in_charge, output ready);
endinterface

// ===== rtl/trd_out_if.sv =====
// Output channel: one tracker or zoom event per transaction.
interface trd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic               notify_gimbal;
    logic               send_stop;
    logic [4:0]         zoom_index;

    modport source (output valid, event_kind, offset_x, offset_y, notify_gimbal,
                    send_stop, zoom_index, input ready);
    modport sink (input valid, event_kind, offset_x, offset_y, notify_gimbal,
                  send_stop, zoom_index, output ready);
endinterface

// ===== rtl/trd_cfg.sv =====
// APB-style configuration registers of the deframer.
module trd_cfg
    import trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [7:0] r_lost_limit;
    logic [7:0] r_notify_interval;
    logic       wr_en;
    t_reg_idx   reg_idx;

    // Decode the word address
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write registers in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_limit      <= LostLimitRst;
            r_notify_interval <= NotifyIntervalRst;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LOST_LIMIT:      r_lost_limit      <= pwdata[7:0];
                REG_NOTIFY_INTERVAL: r_notify_interval <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        case (reg_idx)
            REG_LOST_LIMIT:      prdata = {24'd0, r_lost_limit};
            REG_NOTIFY_INTERVAL: prdata = {24'd0, r_notify_interval};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.lost_limit      = r_lost_limit;
    assign o_cfg.notify_interval = r_notify_interval;

endmodule

// ===== rtl/trd_frame.sv =====
// Byte collector: finds headers, counts packet bytes and holds the payload bytes.
`include "assert_macros.svh"
module trd_frame
    import trd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_frame     o_frame
);

    logic [2:0] r_count;
    logic       r_is_zoom;
    logic [7:0] r_bytes [1:6];

    logic       hdr_ok;
    logic       cur_zoom;
    logic       take;
    logic       last;

    // Open a packet on a known header, else stay in the current one
    always_comb begin
        hdr_ok   = (i_byte == HdrTrack) || (i_byte == HdrZoom);
        cur_zoom = (r_count == '0) ? (i_byte == HdrZoom) : r_is_zoom;
        take     = (r_count != '0) || hdr_ok;
        last     = cur_zoom ? (r_count == LastZoom) : (r_count == LastTrack);
    end

    // Advance the byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_is_zoom <= 1'b0;
        end else if (i_accept && take) begin
            if (r_count == '0) begin
                r_is_zoom <= cur_zoom;
            end
            r_count <= last ? '0 : r_count + 3'd1;
        end
    end

    // Capture the payload bytes; the header and the trailing byte of a track packet are not kept
    always_ff @(posedge i_clk) begin
        for (int i = 1; i <= 6; i++) begin
            if (i_accept && (r_count == 3'(i))) begin
                r_bytes[i] <= i_byte;
            end
        end
    end

    // All fields of a completed packet come from stored bytes
    always_comb begin
        o_frame.done    = take && last;
        o_frame.is_zoom = cur_zoom;
        o_frame.addr    = r_bytes[1];
        o_frame.x       = $signed({r_bytes[3], r_bytes[2]});
        o_frame.y       = $signed({r_bytes[5], r_bytes[4]});
        o_frame.held    = r_bytes[6][HeldBit];
        o_frame.zpos    = {r_bytes[2][3:0], r_bytes[3][3:0], r_bytes[4][3:0],
                           r_bytes[5][3:0]};
    end

    `ASSERT_PROP(a_count_wraps_on_done, i_clk, i_rst_n, i_accept && o_frame.done |=> r_count == '0)

endmodule

// ===== rtl/trd_zoom.sv =====
// Nearest zoom table step by parallel compare against constant midpoints.
module trd_zoom
    import trd_pkg::*;
(
    input  logic [15:0] i_pos,
    output logic [4:0]  o_index
);

    logic [16:0] pos2;
    logic [4:0]  idx;

    // Step i wins once the position reaches the midpoint below it (ties go up)
    always_comb begin
        pos2 = {i_pos, 1'b0};
        idx  = '0;
        for (int i = 1; i <= ZoomMax; i++) begin
            if (pos2 >= zoom_mid(i)) begin
                idx = 5'(i);
            end
        end
        o_index = idx;
    end

endmodule

// ===== rtl/trd_event.sv =====
// Tracking state and result building for completed packets.
`include "assert_macros.svh"
module trd_event
    import trd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_frame  i_frame,
    input  logic    i_in_charge,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic       r_tracing;
    logic [7:0] r_miss;
    logic [7:0] r_notify_cnt;
    logic       n_tracing;
    logic [7:0] n_miss;
    logic [7:0] n_notify_cnt;
    logic [4:0] zoom_index;

    trd_zoom u_zoom (
        .i_pos   (i_frame.zpos),
        .o_index (zoom_index)
    );

    // Build the result and the next tracking state
    always_comb begin
        o_res        = '0;
        n_tracing    = r_tracing;
        n_miss       = r_miss;
        n_notify_cnt = r_notify_cnt;
        if (i_frame.done) begin
            if (!i_frame.is_zoom) begin
                if (i_frame.addr == AddrTrack) begin
                    if (i_frame.held) begin
                        n_tracing        = 1'b1;
                        n_miss           = '0;
                        o_res.valid      = 1'b1;
                        o_res.event_kind = EV_TRACKED;
                        o_res.offset_x   = i_frame.x;
                        o_res.offset_y   = i_frame.y;
                        if (r_notify_cnt < i_cfg.notify_interval) begin
                            n_notify_cnt = r_notify_cnt + 8'd1;
                        end else begin
                            n_notify_cnt        = '0;
                            o_res.notify_gimbal = 1'b1;
                        end
                    end else if (r_tracing) begin
                        n_miss = r_miss + 8'd1;
                        if (r_miss >= i_cfg.lost_limit) begin
                            n_tracing           = 1'b0;
                            o_res.valid         = 1'b1;
                            o_res.event_kind    = EV_LOST;
                            o_res.notify_gimbal = 1'b1;
                            o_res.send_stop     = i_in_charge;
                        end
                    end
                end
            end else if (i_frame.addr == AddrZoom) begin
                o_res.valid      = 1'b1;
                o_res.event_kind = EV_ZOOM;
                o_res.zoom_index = zoom_index;
            end
        end
    end

    // Commit tracking state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracing    <= 1'b0;
            r_miss       <= '0;
            r_notify_cnt <= '0;
        end else if (i_accept) begin
            r_tracing    <= n_tracing;
            r_miss       <= n_miss;
            r_notify_cnt <= n_notify_cnt;
        end
    end

    `ASSERT_PROP(a_loss_ends_trace, i_clk, i_rst_n, i_accept && o_res.valid && o_res.event_kind == EV_LOST |=> !r_tracing)
    `ASSERT_PROP(a_track_starts_trace, i_clk, i_rst_n, i_accept && o_res.valid && o_res.event_kind == EV_TRACKED |=> r_tracing && r_miss == '0)
    `ASSERT_PROP(a_loss_fields, i_clk, i_rst_n, o_res.valid && o_res.event_kind == EV_LOST |-> o_res.offset_x == '0 && o_res.offset_y == '0 && o_res.notify_gimbal)
    `ASSERT_NEVER(a_stop_only_on_loss, i_clk, i_rst_n, o_res.send_stop && o_res.event_kind != EV_LOST)

endmodule

// ===== rtl/tracker_reply_deframer.sv =====
// Top level of the tracker reply deframer.
//
//  channel   direction  transaction     payload
//  i_in      in         one byte        rx_byte, tracker_in_charge
//  o_out     out        one event       event_kind, offset_x, offset_y,
//                                       notify_gimbal, send_stop, zoom_index
//  apb       in/out     register write  psel, penable, pwrite, paddr, pwdata
//
// One byte per cycle unless o_out stalls. A packet's event appears on o_out in
// the cycle after its last byte is taken; all packet fields are read from stored
// bytes, so the path is the zoom midpoint compare and the result register.
// Synchronous active-low reset clears the byte counter, tracking state and result valid flag.
// o_out stalls hold the result register; i_in keeps flowing while the result
// register is empty or being drained in the same cycle.
module tracker_reply_deframer
    import trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    trd_in_if.sink      i_in,
    trd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_frame  frame;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    // Take a byte whenever the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    trd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    trd_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.rx_byte),
        .o_frame  (frame)
    );

    trd_event u_event (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_frame     (frame),
        .i_in_charge (i_in.tracker_in_charge),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= res.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (accept && res.valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_kind    = r_out.event_kind;
    assign o_out.offset_x      = r_out.offset_x;
    assign o_out.offset_y      = r_out.offset_y;
    assign o_out.notify_gimbal = r_out.notify_gimbal;
    assign o_out.send_stop     = r_out.send_stop;
    assign o_out.zoom_index    = r_out.zoom_index;

endmodule

// ===== tb/tracker_reply_deframer_test.sv =====
// Self-checking testbench for the tracker reply deframer: byte stream in, events out.
module tracker_reply_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import trd_pkg::*;

    // Framing constants, kept apart from the design's package
    localparam logic [7:0] TrackHeader = 8'hBB;
    localparam logic [7:0] TrackAddr   = 8'h01;
    localparam logic [7:0] ZoomHeader  = 8'h90;
    localparam logic [7:0] ZoomAddr    = 8'h50;
    localparam logic [7:0] HeldMask    = 8'h02;
    localparam logic [3:0] TrackLen    = 4'd8;
    localparam logic [3:0] ZoomLen     = 4'd7;
    localparam int         StepCount   = 41;
    localparam int         TopStep     = 29;
    localparam int         ReportLimit = 10;

    // Zoom lens position of each step
    localparam logic [15:0] ZoomStepPos [StepCount] = '{
        16'h0000, 16'h16A1, 16'h2063, 16'h2628, 16'h2A1D, 16'h2D13, 16'h2F6D, 16'h3161,
        16'h330D, 16'h3486, 16'h35D7, 16'h3709, 16'h3820, 16'h3920, 16'h3A0A, 16'h3ADD,
        16'h3B9C, 16'h3C46, 16'h3CDC, 16'h3D60, 16'h3DD4, 16'h3E39, 16'h3E90, 16'h3EDC,
        16'h3F1E, 16'h3F57, 16'h3F8A, 16'h3FB6, 16'h3FDC, 16'h4000, 16'h6000, 16'h6A80,
        16'h7000, 16'h7300, 16'h7540, 16'h76C0, 16'h7800, 16'h78C0, 16'h7980, 16'h7A00,
        16'h7AC0
    };

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_CHOPPY,
        SINK_CHOKED
    } t_sink_mode;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               notify;
        logic               stop;
        logic [4:0]         step;
    } t_reply_event;

    // Deframer state mirror plus the queue of events it owes
    class t_reply_event_book;
        logic [7:0]   lost_limit;
        logic [7:0]   notify_interval;
        logic [3:0]   byte_idx;
        logic         zoom_pkt;
        logic [7:0]   frame [8];
        logic         tracing;
        logic [7:0]   misses;
        logic [7:0]   held_count;
        t_reply_event due [$];
        int           failures;

        function new();
            lost_limit      = LostLimitRst;
            notify_interval = NotifyIntervalRst;
            byte_idx        = '0;
            zoom_pkt        = 1'b0;
            tracing         = 1'b0;
            misses          = '0;
            held_count      = '0;
            failures        = 0;
            foreach (frame[i]) frame[i] = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [7:0] value);
            if (idx == REG_LOST_LIMIT) begin
                lost_limit = value;
            end else begin
                notify_interval = value;
            end
        endfunction

        // First step at or above the position, or the one below if strictly nearer
        function logic [4:0] nearest_step(logic [15:0] pos);
            int pick;
            pick = StepCount;
            for (int i = 0; i < StepCount; i++) begin
                if (ZoomStepPos[i] >= pos) begin
                    pick = i;
                    if (ZoomStepPos[i] != pos && i > 0 &&
                        (ZoomStepPos[i] - pos) > (pos - ZoomStepPos[i - 1])) begin
                        pick = i - 1;
                    end
                    break;
                end
            end
            if (pick > TopStep) begin
                pick = TopStep;
            end
            return pick[4:0];
        endfunction

        // Advance the framer by one accepted byte and queue any event it completes
        function void take_byte(logic [7:0] b, logic in_charge);
            t_reply_event ev;
            logic         tolerated;
            if (byte_idx == 0) begin
                if (b == TrackHeader) begin
                    zoom_pkt = 1'b0;
                end else if (b == ZoomHeader) begin
                    zoom_pkt = 1'b1;
                end else begin
                    return;
                end
            end
            frame[byte_idx[2:0]] = b;
            byte_idx = byte_idx + 4'd1;
            if (byte_idx < (zoom_pkt ? ZoomLen : TrackLen)) begin
                return;
            end
            byte_idx = '0;

            ev.kind   = EV_TRACKED;
            ev.dx     = '0;
            ev.dy     = '0;
            ev.notify = 1'b0;
            ev.stop   = 1'b0;
            ev.step   = '0;

            if (!zoom_pkt) begin
                if (frame[1] != TrackAddr) begin
                    return;
                end
                // Held target: report offsets, pulse notify every interval+1 packets
                if ((frame[6] & HeldMask) != 0) begin
                    tracing = 1'b1;
                    misses  = '0;
                    ev.dx   = {frame[3], frame[2]};
                    ev.dy   = {frame[5], frame[4]};
                    if (held_count < notify_interval) begin
                        held_count = held_count + 8'd1;
                    end else begin
                        held_count = '0;
                        ev.notify  = 1'b1;
                    end
                    due.push_back(ev);
                    return;
                end
                if (!tracing) begin
                    return;
                end
                // Count the miss; declare loss once the limit is passed
                tolerated = misses < lost_limit;
                misses    = misses + 8'd1;
                if (tolerated) begin
                    return;
                end
                tracing   = 1'b0;
                ev.kind   = EV_LOST;
                ev.notify = 1'b1;
                ev.stop   = in_charge;
                due.push_back(ev);
                return;
            end

            if (frame[1] != ZoomAddr) begin
                return;
            end
            ev.kind = EV_ZOOM;
            ev.step = nearest_step({frame[2][3:0], frame[3][3:0],
                                    frame[4][3:0], frame[5][3:0]});
            due.push_back(ev);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= ReportLimit) begin
                $display("%0t ns: %s", $time, msg);
            end
        endfunction

        // Compare one delivered event against the oldest one owed
        function void match_event(t_reply_event got);
            t_reply_event want;
            if (due.size() == 0) begin
                note_failure($sformatf("event with none due: kind %0d x %0d y %0d step %0d",
                                       got.kind, got.dx, got.dy, got.step));
                return;
            end
            want = due.pop_front();
            if (got.kind !== want.kind || got.dx !== want.dx || got.dy !== want.dy ||
                got.notify !== want.notify || got.stop !== want.stop ||
                got.step !== want.step) begin
                note_failure($sformatf({"event mismatch: expected kind %0d x %0d y %0d ",
                    "notify %0b stop %0b step %0d, got kind %0d x %0d y %0d notify %0b ",
                    "stop %0b step %0d"},
                    want.kind, want.dx, want.dy, want.notify, want.stop, want.step,
                    got.kind, got.dx, got.dy, got.notify, got.stop, got.step));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    trd_in_if  in_ch ();
    trd_out_if out_ch ();

    t_reply_event_book book = new();
    int burst_left = 0;
    int packet_bytes_sent = 0;

    tracker_reply_deframer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        #400000;
        $display("tracker_reply_deframer_test: FAIL");
        $finish;
    end

    // Receiver: switch between open, choppy and choked stretches
    initial begin
        t_sink_mode mode;
        int         left;
        mode = SINK_OPEN;
        left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_sink_mode'($urandom_range(0, 2));
                left = $urandom_range(10, 90);
            end else begin
                left--;
            end
            case (mode)
                SINK_OPEN: out_ch.ready <= 1'b1;
                SINK_CHOPPY: out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Check every event transaction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            book.match_event(t_reply_event'{out_ch.event_kind, out_ch.offset_x,
                                            out_ch.offset_y, out_ch.notify_gimbal,
                                            out_ch.send_stop, out_ch.zoom_index});
        end
    end

    // Write one register through the APB port
    task automatic apb_write(input t_reg_idx idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        book.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hand one byte over; drop valid for a random gap at the end of each burst
    task automatic send_byte(input logic [7:0] b);
        logic charge;
        charge = 1'($urandom_range(0, 1));
        in_ch.valid             <= 1'b1;
        in_ch.rx_byte           <= b;
        in_ch.tracker_in_charge <= charge;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        book.take_byte(b, charge);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_track(input logic [7:0] addr, input logic [15:0] x,
                              input logic [15:0] y, input logic [7:0] status);
        send_byte(TrackHeader);
        send_byte(addr);
        send_byte(x[7:0]);
        send_byte(x[15:8]);
        send_byte(y[7:0]);
        send_byte(y[15:8]);
        send_byte(status);
        send_byte(8'($urandom));
        packet_bytes_sent += 8;
    endtask

    // High nibbles carry junk the block must ignore
    task automatic send_zoom(input logic [7:0] addr, input logic [15:0] pos);
        send_byte(ZoomHeader);
        send_byte(addr);
        send_byte({4'($urandom), pos[15:12]});
        send_byte({4'($urandom), pos[11:8]});
        send_byte({4'($urandom), pos[7:4]});
        send_byte({4'($urandom), pos[3:0]});
        send_byte(8'($urandom));
        packet_bytes_sent += 7;
    endtask

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed packets, some with bad addresses, some stray bytes
    task automatic random_packet();
        int          pick;
        int          k;
        logic [7:0]  addr;
        logic [15:0] pos;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_track(TrackAddr, pick_offset(), pick_offset(), 8'($urandom) | HeldMask);
        end else if (pick < 65) begin
            repeat ($urandom_range(1, 4)) begin
                send_track(TrackAddr, pick_offset(), pick_offset(), 8'($urandom) & ~HeldMask);
            end
        end else if (pick < 85) begin
            k = $urandom_range(0, StepCount - 1);
            case ($urandom_range(0, 3))
                0: pos = ZoomStepPos[k];
                1: pos = ZoomStepPos[k] + 16'($urandom_range(0, 6)) - 16'd3;
                2: pos = (k == 0) ? 16'h0000 : 16'((17'(ZoomStepPos[k - 1]) +
                         17'(ZoomStepPos[k])) >> 1) + 16'($urandom_range(0, 2)) - 16'd1;
                default: pos = 16'($urandom);
            endcase
            send_zoom(ZoomAddr, pos);
        end else if (pick < 93) begin
            do addr = 8'($urandom); while (addr == TrackAddr || addr == ZoomAddr);
            if ($urandom_range(0, 1) == 0) begin
                send_track(addr, pick_offset(), pick_offset(), 8'($urandom));
            end else begin
                send_zoom(addr, 16'($urandom));
            end
        end else begin
            // Stray bytes; a header among them opens a misaligned packet
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
    endtask

    // Let every owed event drain, plus slack for a packet that owes none
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (book.due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] lost, input logic [7:0] interval,
                             input int target);
        settle();
        apb_write(REG_LOST_LIMIT, lost);
        apb_write(REG_NOTIFY_INTERVAL, interval);
        while (packet_bytes_sent < target) random_packet();
    endtask

    // Main sequence
    initial begin
        i_rst_n                 <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        in_ch.valid             <= 1'b0;
        in_ch.rx_byte           <= '0;
        in_ch.tracker_in_charge <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: miss before tracing, extreme offsets, stray bytes, zoom past the table
        send_track(TrackAddr, 16'hFFFF, 16'h0000, 8'hFD);
        send_track(TrackAddr, 16'h8000, 16'h7FFF, 8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_zoom(ZoomAddr, 16'hFFFF);

        // Random under the reset settings, then under a spread of settings
        while (packet_bytes_sent < 250) random_packet();
        run_phase(8'd0, 8'd0, 420);
        run_phase(8'd255, 8'd255, 600);
        run_phase(8'd2, 8'd3, 800);
        run_phase(8'd1, 8'd255, 950);
        run_phase(8'd0, 8'd1, 1100);
        run_phase(8'($urandom_range(0, 6)), 8'($urandom), 1250);

        in_ch.valid <= 1'b0;
        while (book.due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (book.failures == 0) begin
            $display("tracker_reply_deframer_test: PASS");
        end else begin
            $display("tracker_reply_deframer_test: FAIL");
        end
        $finish;
    end

endmodule
